// ===== src/per_key_flood_limiter_macros.svh =====
// Assertion macros used by the flood limiter top level.
`ifndef PER_KEY_FLOOD_LIMITER_MACROS_SVH
`define PER_KEY_FLOOD_LIMITER_MACROS_SVH

// Same-cycle implication, sampled on i_clk and quiet during reset.
`define PKFL_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on i_clk and quiet during reset.
`define PKFL_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/pkfl_pkg.sv =====
// Shared types, sizes and codes of the per-key flood limiter.
package pkfl_pkg;

    localparam int TABLE_DEPTH = 64;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int KEY_W       = 32;
    localparam int CNT_W       = 16;
    localparam int TIME_W      = 32;
    localparam int PURGE_W     = 7;
    localparam int ADDR_W      = 3;
    localparam int DATA_W      = 32;

    typedef enum logic {
        OP_CHECK = 1'b0,
        OP_PURGE = 1'b1
    } t_op;

    typedef enum logic [1:0] {
        ST_KNOWN    = 2'd0,
        ST_INSERTED = 2'd1,
        ST_FULL     = 2'd2,
        ST_PURGED   = 2'd3
    } t_status;

    typedef enum logic {
        REG_COUNT_LIMIT = 1'b0,
        REG_WINDOW      = 1'b1
    } t_reg_idx;

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_SCAN   = 4'b0010,
        S_INSERT = 4'b0100,
        S_DONE   = 4'b1000
    } t_state;

    typedef struct packed {
        logic              valid;
        logic [KEY_W-1:0]  key;
        logic [CNT_W-1:0]  count;
        logic [TIME_W-1:0] stamp;
    } t_entry;

    // Control from the sequencer to the update unit at the end of the ring.
    typedef struct packed {
        logic scan;
        logic insert;
        t_op  op;
    } t_head_ctl;

    // What the update unit saw in the entry passing it this cycle.
    typedef struct packed {
        logic hit;
        logic flood;
        logic free;
        logic aged;
    } t_head_flags;

endpackage

// ===== src/per_key_flood_limiter.sv =====
// Top level of the per-key flood limiter: ring of entry cells and its sequencer.
//
//  channel   direction  handshake             payload
//  s_*       in         s_tvalid / s_tready   tdata {now, key}, tuser op
//  m_*       out        m_tvalid / m_tready   tdata {purged_count, flooded}, tuser status
//  apb       in         psel/penable/pwrite   count_limit at 0x0, window_ticks at 0x4
//
//  A purge, or a check of a known key, presents its result after the ring rotates once
//  past the single update unit, one entry per cycle; the block is idle again, ready for
//  the next item, in the same cycle as the result appears.
//  A check that inserts rotates on until a free cell reaches the head and is filled.
//  Reset clears the valid bit of every cell at once; there is no
//  clearing pass. A new item is taken only in idle, while an earlier result may still
//  wait in the output register; a stalled output holds the block before its next item.
`include "per_key_flood_limiter_macros.svh"

module per_key_flood_limiter (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // APB configuration port
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [pkfl_pkg::ADDR_W-1:0]   paddr,
    input  logic [pkfl_pkg::DATA_W-1:0]   pwdata,
    output logic [pkfl_pkg::DATA_W-1:0]   prdata,
    output logic                          pready,
    // input items
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [63:0]                   s_tdata,  // [31:0] key, [63:32] now
    input  logic                          s_tuser,  // [0] op
    // result items
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [7:0]                    m_tdata,  // [0] flooded, [7:1] purged_count
    output logic [1:0]                    m_tuser   // [1:0] status
);
    import pkfl_pkg::*;

    // configuration
    logic [CNT_W-1:0]  r_count_limit;
    logic [TIME_W-1:0] r_window;
    logic              w_cfg_wr;
    t_reg_idx          w_cfg_idx;

    assign pready    = 1'b1;
    assign w_cfg_wr  = psel && penable && pwrite;
    assign w_cfg_idx = t_reg_idx'(paddr[2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count_limit <= CNT_W'(5);
            r_window      <= TIME_W'(1000);
        end else if (w_cfg_wr) begin
            unique case (w_cfg_idx)
                REG_COUNT_LIMIT: r_count_limit <= pwdata[CNT_W-1:0];
                REG_WINDOW:      r_window      <= pwdata[TIME_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (w_cfg_idx)
            REG_COUNT_LIMIT: prdata = {{(DATA_W-CNT_W){1'b0}}, r_count_limit};
            REG_WINDOW:      prdata = r_window;
            default:         prdata = '0;
        endcase
    end

    // sequencer state and the item under work
    t_state            r_state, n_state;
    t_op               r_op;
    logic [KEY_W-1:0]  r_key;
    logic [TIME_W-1:0] r_now;
    logic [IDX_W-1:0]  r_scan_cnt;
    logic              r_hit;
    logic              r_free_seen;
    logic              r_flooded;
    logic [PURGE_W-1:0] r_purged;
    t_status           r_status;

    // output register
    logic               r_m_valid;
    logic               r_m_flooded;
    t_status            r_m_status;
    logic [PURGE_W-1:0] r_m_purged;

    logic        w_accept;
    logic        w_scan_last;
    logic        w_out_free;
    logic        w_shift;
    t_head_ctl   w_head_ctl;
    t_head_flags w_flags;
    t_entry      w_head_out;
    t_entry      w_cell [TABLE_DEPTH];

    assign s_tready    = (r_state == S_IDLE);
    assign w_accept    = s_tvalid && s_tready;
    assign w_scan_last = (r_scan_cnt == IDX_W'(TABLE_DEPTH - 1));
    assign w_out_free  = !r_m_valid || m_tready;
    assign w_shift     = (r_state == S_SCAN) || (r_state == S_INSERT);

    assign w_head_ctl.scan   = (r_state == S_SCAN);
    assign w_head_ctl.insert = (r_state == S_INSERT);
    assign w_head_ctl.op     = r_op;

    // The ring: every cell takes its upper neighbour, the top cell takes the
    // rewritten head entry.
    for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
        if (g == TABLE_DEPTH - 1) begin : g_top
            pkfl_cell u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_shift (w_shift),
                .i_entry (w_head_out),
                .o_entry (w_cell[g])
            );
        end else begin : g_mid
            pkfl_cell u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_shift (w_shift),
                .i_entry (w_cell[g+1]),
                .o_entry (w_cell[g])
            );
        end
    end

    pkfl_head u_head (
        .i_ctl         (w_head_ctl),
        .i_key         (r_key),
        .i_now         (r_now),
        .i_count_limit (r_count_limit),
        .i_window      (r_window),
        .i_entry       (w_cell[0]),
        .o_entry       (w_head_out),
        .o_flags       (w_flags)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) n_state = S_SCAN;
            end
            S_SCAN: begin
                if (w_scan_last) begin
                    // Keys are unique in the table, so a miss with a free cell
                    // seen means the key must go into one.
                    if (r_op == OP_CHECK && !(r_hit || w_flags.hit) &&
                        (r_free_seen || w_flags.free)) begin
                        n_state = S_INSERT;
                    end else begin
                        n_state = S_DONE;
                    end
                end
            end
            S_INSERT: begin
                if (w_flags.free) n_state = S_DONE;
            end
            S_DONE: begin
                if (w_out_free) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scan_cnt  <= '0;
            r_hit       <= 1'b0;
            r_free_seen <= 1'b0;
            r_flooded   <= 1'b0;
            r_purged    <= '0;
            r_status    <= ST_KNOWN;
        end else if (w_accept) begin
            r_scan_cnt  <= '0;
            r_hit       <= 1'b0;
            r_free_seen <= 1'b0;
            r_flooded   <= 1'b0;
            r_purged    <= '0;
        end else if (r_state == S_SCAN) begin
            r_scan_cnt <= r_scan_cnt + IDX_W'(1);
            if (w_flags.hit)   r_hit       <= 1'b1;
            if (w_flags.free)  r_free_seen <= 1'b1;
            if (w_flags.flood) r_flooded   <= 1'b1;
            if (w_flags.aged && (r_purged != '1)) begin
                r_purged <= r_purged + PURGE_W'(1);
            end
            if (w_scan_last) begin
                priority if (r_op == OP_PURGE)          r_status <= ST_PURGED;
                else if (r_hit || w_flags.hit)          r_status <= ST_KNOWN;
                else if (r_free_seen || w_flags.free)   r_status <= ST_INSERTED;
                else                                    r_status <= ST_FULL;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_op  <= t_op'(s_tuser);
            r_key <= s_tdata[KEY_W-1:0];
            r_now <= s_tdata[KEY_W +: TIME_W];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (r_state == S_DONE && w_out_free) begin
            r_m_valid <= 1'b1;
        end else if (m_tready) begin
            r_m_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_DONE && w_out_free) begin
            r_m_flooded <= r_flooded;
            r_m_status  <= r_status;
            r_m_purged  <= r_purged;
        end
    end

    assign m_tvalid = r_m_valid;
    assign m_tdata  = {r_m_purged, r_m_flooded};
    assign m_tuser  = r_m_status;

    `PKFL_ASSERT_NEXT(a_accept_starts_scan, w_accept, r_state == S_SCAN,
        "accepted item did not start a scan")
    `PKFL_ASSERT_NEXT(a_done_loads_output, r_state == S_DONE && w_out_free, m_tvalid,
        "finished item did not reach the output register")
    `PKFL_ASSERT_NOW(a_insert_only_on_miss, r_state == S_INSERT,
        r_op == OP_CHECK && !r_hit && r_free_seen,
        "insert pass entered without a missed check and a free cell")
    `PKFL_ASSERT_NOW(a_purge_bounded, r_state == S_SCAN,
        32'(r_purged) <= 32'(r_scan_cnt),
        "purged count ran ahead of the cells scanned")
    `PKFL_ASSERT_NOW(a_flood_needs_hit, r_flooded && r_state != S_IDLE,
        r_hit && r_op == OP_CHECK,
        "flood flagged without a matching key")

endmodule

// ===== src/pkfl_cell.sv =====
// One table entry of the ring; passes its entry to the neighbour on each shift.
module pkfl_cell (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_shift,
    input  pkfl_pkg::t_entry i_entry,
    output pkfl_pkg::t_entry o_entry
);
    import pkfl_pkg::*;

    logic              r_valid;
    logic [KEY_W-1:0]  r_key;
    logic [CNT_W-1:0]  r_count;
    logic [TIME_W-1:0] r_stamp;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_shift) begin
            r_valid <= i_entry.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_key   <= i_entry.key;
            r_count <= i_entry.count;
            r_stamp <= i_entry.stamp;
        end
    end

    assign o_entry = {r_valid, r_key, r_count, r_stamp};

endmodule

// ===== src/pkfl_head.sv =====
// Update unit that rewrites the entry leaving the head of the ring.
module pkfl_head (
    input  pkfl_pkg::t_head_ctl            i_ctl,
    input  logic [pkfl_pkg::KEY_W-1:0]     i_key,
    input  logic [pkfl_pkg::TIME_W-1:0]    i_now,
    input  logic [pkfl_pkg::CNT_W-1:0]     i_count_limit,
    input  logic [pkfl_pkg::TIME_W-1:0]    i_window,
    input  pkfl_pkg::t_entry               i_entry,
    output pkfl_pkg::t_entry               o_entry,
    output pkfl_pkg::t_head_flags          o_flags
);
    import pkfl_pkg::*;

    logic [TIME_W-1:0] w_age;

    // Wrapping difference: the age is taken modulo the tick counter range.
    assign w_age = i_now - i_entry.stamp;

    always_comb begin
        o_entry = i_entry;
        o_flags = '0;
        if (i_ctl.insert) begin
            if (!i_entry.valid) begin
                o_entry.valid = 1'b1;
                o_entry.key   = i_key;
                o_entry.count = '0;
                o_entry.stamp = i_now;
                o_flags.free  = 1'b1;
            end
        end else if (i_ctl.scan) begin
            if (i_ctl.op == OP_PURGE) begin
                if (i_entry.valid && (w_age > i_window)) begin
                    o_entry.valid = 1'b0;
                    o_flags.aged  = 1'b1;
                end
            end else if (i_entry.valid) begin
                if (i_entry.key == i_key) begin
                    o_flags.hit = 1'b1;
                    if (i_entry.count < i_count_limit) begin
                        o_entry.count = i_entry.count + CNT_W'(1);
                    end else begin
                        o_flags.flood = (w_age < i_window);
                        o_entry.stamp = i_now;
                        o_entry.count = '0;
                    end
                end
            end else begin
                o_flags.free = 1'b1;
            end
        end
    end

endmodule
